// ===== design/lzfd_pkg.sv =====
// Shared types and constants for the LZSS frame decompressor.
`default_nettype none

package lzfd_pkg;

    localparam int DIST_W    = 11;
    localparam int LEN_W     = 6;
    localparam int FLAG_BITS = 8;

    localparam logic [LEN_W-1:0] LEN_BIAS        = 6'd3;
    localparam logic [15:0]      FRAME_SIZE_RST  = 16'd23040;
    localparam logic [7:0]       FRAME_TOTAL_RST = 8'd16;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic REG_FRAME_SIZE  = 1'b0;
    localparam logic REG_FRAME_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        PHASE_FLAG,
        PHASE_ITEM,
        PHASE_HIGH
    } phase_t;

    typedef struct packed {
        logic latch_in;
        logic start;
        logic load_flag;
        logic load_tlow;
        logic load_match;
        logic ram_rd;
        logic emit;
        logic emit_lit;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic   is_start;
        logic   stream_idle;
        phase_t phase;
        logic   flag_bit;
        logic   slot_free;
        logic   copy_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/lzfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lzfd_ctrl.sv =====
// Controller state machine sequencing parse, literal emit and match copy.
`default_nettype none

module lzfd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lzfd_pkg::dp_status_t status,
    output lzfd_pkg::ctrl_cmd_t      cmd
);

    import lzfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LIT,
        S_RD,
        S_CP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (status.is_start)
                begin
                    cmd.start = 1'b1;
                end
                else if (!status.stream_idle)
                begin
                    case (status.phase)
                        PHASE_FLAG:
                        begin
                            cmd.load_flag = 1'b1;
                        end
                        PHASE_ITEM:
                        begin
                            if (status.flag_bit)
                            begin
                                cmd.load_tlow = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LIT;
                            end
                        end
                        default:
                        begin
                            cmd.load_match = 1'b1;
                            state_next     = S_RD;
                        end
                    endcase
                end
            end
            S_LIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_lit   = 1'b1;
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_CP;
            end
            S_CP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_final = status.copy_last;
                    state_next     = status.copy_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lzfd_datapath.sv =====
// Datapath: parse state, frame counters, history addressing and output register.
`default_nettype none

module lzfd_datapath #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lzfd_pkg::ctrl_cmd_t cmd,
    output lzfd_pkg::dp_status_t     status,
    input  wire logic                command,
    input  wire logic [7:0]          data_in,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               out_byte,
    output logic                     last,
    output logic                     frame_end,
    output logic                     stream_end
);

    import lzfd_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int WRAPS = ((2 ** DIST_W) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

    logic [15:0]       frame_size_reg;
    logic [7:0]        frame_total_reg;
    logic              cmd_reg;
    logic [7:0]        data_reg;
    phase_t            phase_reg,      phase_next;
    logic [7:0]        flag_reg,       flag_next;
    logic [3:0]        bit_idx_reg,    bit_idx_next;
    logic [7:0]        tlow_reg,       tlow_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]        frames_left_reg, frames_left_next;
    logic [AW-1:0]     wp_reg,         wp_next;
    logic [AW-1:0]     src_reg,        src_next;
    logic [LEN_W-1:0]  len_left_reg,   len_left_next;
    logic              out_valid_reg,  out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              last_reg;
    logic              frame_end_reg,  frame_end_val;
    logic              stream_end_reg, stream_end_val;

    logic [7:0]        emit_byte;
    logic [7:0]        ram_rdata;
    logic [15:0]       bl_dec;
    logic [7:0]        fl_dec;
    logic [3:0]        bit_inc;
    logic [DIST_W-1:0] match_dist;
    logic signed [12:0] src_calc;
    logic              slot_free;

    assign slot_free  = !out_valid_reg || out_ready;
    assign emit_byte  = cmd.emit_lit ? data_reg : ram_rdata;
    assign bl_dec     = (bytes_left_reg != '0) ? bytes_left_reg - 16'd1 : '0;
    assign fl_dec     = (frames_left_reg != '0) ? frames_left_reg - 8'd1 : '0;
    assign bit_inc    = bit_idx_reg + 4'd1;
    assign match_dist = {data_reg[2:0], tlow_reg};

    always_comb
    begin
        src_calc = signed'(13'(wp_reg)) - signed'(13'(match_dist)) - 13'sd1;
        for (int i = 0; i < WRAPS; i++)
        begin
            if (src_calc[12])
            begin
                src_calc = src_calc + 13'(HISTORY_DEPTH);
            end
        end
    end

    always_comb
    begin
        status.is_start    = (cmd_reg == CMD_START);
        status.stream_idle = (frames_left_reg == '0);
        status.phase       = phase_reg;
        status.flag_bit    = flag_reg[bit_idx_reg[2:0]];
        status.slot_free   = slot_free;
        status.copy_last   = (len_left_reg == LEN_W'(1));
    end

    always_comb
    begin
        phase_next       = phase_reg;
        flag_next        = flag_reg;
        bit_idx_next     = bit_idx_reg;
        tlow_next        = tlow_reg;
        bytes_left_next  = bytes_left_reg;
        frames_left_next = frames_left_reg;
        wp_next          = wp_reg;
        src_next         = src_reg;
        len_left_next    = len_left_reg;
        frame_end_val    = 1'b0;
        stream_end_val   = 1'b0;
        out_valid_next   = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.start)
        begin
            wp_next      = '0;
            phase_next   = PHASE_FLAG;
            flag_next    = '0;
            bit_idx_next = '0;
            tlow_next    = '0;
            if (frame_size_reg == '0 || frame_total_reg == '0)
            begin
                bytes_left_next  = '0;
                frames_left_next = '0;
            end
            else
            begin
                bytes_left_next  = frame_size_reg;
                frames_left_next = frame_total_reg;
            end
        end
        if (cmd.load_flag)
        begin
            flag_next    = data_reg;
            bit_idx_next = '0;
            phase_next   = PHASE_ITEM;
        end
        if (cmd.load_tlow)
        begin
            tlow_next  = data_reg;
            phase_next = PHASE_HIGH;
        end
        if (cmd.load_match)
        begin
            src_next      = src_calc[AW-1:0];
            len_left_next = {1'b0, data_reg[7:3]} + LEN_BIAS;
        end
        if (cmd.ram_rd)
        begin
            src_next = (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            wp_next         = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            bytes_left_next = bl_dec;
            len_left_next   = len_left_reg - 1'b1;
            if (cmd.emit_final)
            begin
                bit_idx_next = bit_inc;
                phase_next   = PHASE_ITEM;
                if (bl_dec == '0)
                begin
                    frame_end_val    = 1'b1;
                    phase_next       = PHASE_FLAG;
                    frames_left_next = fl_dec;
                    if (fl_dec == '0)
                    begin
                        stream_end_val = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = frame_size_reg;
                    end
                end
                else if (bit_inc >= 4'(FLAG_BITS))
                begin
                    phase_next = PHASE_FLAG;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg  <= FRAME_SIZE_RST;
            frame_total_reg <= FRAME_TOTAL_RST;
            phase_reg       <= PHASE_FLAG;
            flag_reg        <= '0;
            bit_idx_reg     <= '0;
            tlow_reg        <= '0;
            bytes_left_reg  <= '0;
            frames_left_reg <= '0;
            wp_reg          <= '0;
            src_reg         <= '0;
            len_left_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FRAME_SIZE:  frame_size_reg  <= cfg_data;
                    REG_FRAME_TOTAL: frame_total_reg <= cfg_data[7:0];
                    default:         frame_size_reg  <= frame_size_reg;
                endcase
            end
            phase_reg       <= phase_next;
            flag_reg        <= flag_next;
            bit_idx_reg     <= bit_idx_next;
            tlow_reg        <= tlow_next;
            bytes_left_reg  <= bytes_left_next;
            frames_left_reg <= frames_left_next;
            wp_reg          <= wp_next;
            src_reg         <= src_next;
            len_left_reg    <= len_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg  <= command;
            data_reg <= data_in;
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= emit_byte;
            last_reg       <= cmd.emit_final;
            frame_end_reg  <= frame_end_val;
            stream_end_reg <= stream_end_val;
        end
    end

    lzfd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (cmd.emit),
        .wr_addr (wp_reg),
        .wr_data (emit_byte),
        .rd_en   (cmd.ram_rd),
        .rd_addr (src_reg),
        .rd_data (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;
    assign frame_end  = frame_end_reg;
    assign stream_end = stream_end_reg;

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("emit while output register is occupied");

    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_match |=> (len_left_reg >= LEN_BIAS))
        else $error("match length below minimum");

    a_stream_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_end_reg) |-> (frame_end_reg && last_reg))
        else $error("stream end without frame end on final beat");

    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stream_end_val) |=> (frames_left_reg == '0))
        else $error("frames remain after stream end");

endmodule

`default_nettype wire

// ===== design/lzss_frame_decompressor_unit.sv =====
// Top level of the LZSS frame decompressor: controller, datapath and history RAM.
//
// Usage:
//   Input channel (in_valid/in_ready, command, data_in): a beat with command 0
//   starts a stream of frame_total frames of frame_size bytes; a beat with
//   command 1 carries one compressed byte. Output channel (out_valid/out_ready)
//   delivers one decompressed byte per beat with last, frame_end, stream_end.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 is frame_size, index 1 is frame_total. Write only while idle.
// Timing:
//   A flag byte, token low byte or start is handled in S_DECODE; a literal
//   is then emitted from S_LIT into the output register. A match token high
//   byte loads the match; each copied byte then takes one history RAM read
//   step (S_RD) and one write/emit step (S_CP) through the single read port.
// Stall:
//   A one-entry output register holds the waiting beat; the controller holds
//   in the emit step while it is full, and input is taken again once all
//   bytes of the current item have been loaded into it.
// Reset: counters and parse state clear, stream idle; registers take defaults.
//   History RAM is not cleared.
`default_nettype none

module lzss_frame_decompressor_unit #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [7:0]  data_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             frame_end,
    output logic             stream_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    import lzfd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lzfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lzfd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .command    (command),
        .data_in    (data_in),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last),
        .frame_end  (frame_end),
        .stream_end (stream_end)
    );

endmodule

`default_nettype wire
